[hw/rtl/nv21cr_pkg.sv]
// nv21cr_pkg: shared codes, defaults and types for the nv21 crop/resize/rgb core
// no dependencies; used by nv21cr_store, nv21cr_yuv2rgb and the top level

package nv21cr_pkg;

	// default sizes for the top-level parameters
	localparam int MAX_WIDTH_DEF  = 640;
	localparam int MAX_HEIGHT_DEF = 480;
	localparam int OUT_SIZE_DEF   = 160;

	// input command codes (carried on s_tuser)
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_EMIT  = 2'd2;

	// result status codes (carried on m_tuser)
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_SIZE  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY_BOX = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM   = 3'd5;

	// register reset values
	localparam logic [9:0]         RST_IMAGE_WIDTH  = 10'd640;
	localparam logic [8:0]         RST_IMAGE_HEIGHT = 9'd480;
	localparam logic signed [11:0] RST_BOX_LEFT     = 12'sd0;
	localparam logic signed [11:0] RST_BOX_TOP      = 12'sd0;
	localparam logic signed [11:0] RST_BOX_RIGHT    = 12'sd640;
	localparam logic signed [11:0] RST_BOX_BOTTOM   = 12'sd480;

	// bt.601 integer coefficients
	localparam int COEF_Y    = 298;
	localparam int COEF_RV   = 409;
	localparam int COEF_GU   = 100;
	localparam int COEF_GV   = 208;
	localparam int COEF_BU   = 516;
	localparam int ROUND_ADD = 128;
	localparam int Y_OFFSET  = 16;
	localparam int UV_OFFSET = 128;

	// frame store control word
	typedef struct packed {
		logic clear;   // reset load pointer
		logic load;    // store one byte at load pointer
		logic rd;      // read one byte
	} store_ctl_t;

endpackage

[hw/rtl/nv21cr_store.sv]
// nv21cr_store: frame store memory with load pointer and one registered read port
// depends on nv21cr_pkg (store_ctl_t)

module nv21cr_store #(
	parameter int MAX_WIDTH  = nv21cr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = nv21cr_pkg::MAX_HEIGHT_DEF,
	localparam int DEPTH     = (MAX_WIDTH * MAX_HEIGHT * 3) / 2,
	localparam int RAW       = $clog2(DEPTH) + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nv21cr_pkg::store_ctl_t ctl,
	input  logic [7:0]             wr_byte,
	input  logic [RAW-1:0]         rd_addr,
	output logic [7:0]             rd_data
);

	localparam int IW  = $clog2(DEPTH);
	localparam int PTW = $clog2(DEPTH + 1);

	logic [7:0]     mem [DEPTH];
	logic [PTW-1:0] ptr_q;
	logic [7:0]     rd_q;
	logic           in_range_q;
	logic           rd_in_range;
	logic           wr_ok;

	assign rd_in_range = rd_addr < RAW'(DEPTH);
	assign wr_ok       = ctl.load && (ptr_q < PTW'(DEPTH));

	// pointer sticks at capacity, extra bytes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctl.clear) begin
			ptr_q <= '0;
		end else if (wr_ok) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[ptr_q[IW-1:0]] <= wr_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd && rd_in_range) begin
			rd_q <= mem[rd_addr[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_q <= 1'b0;
		end else if (ctl.rd) begin
			in_range_q <= rd_in_range;
		end
	end

	// addresses past the store read as zero
	assign rd_data = in_range_q ? rd_q : 8'd0;

endmodule

[hw/rtl/nv21cr_yuv2rgb.sv]
// nv21cr_yuv2rgb: two-stage bt.601 yuv to rgb conversion, output as 2c-255 per channel
// depends on nv21cr_pkg (coefficients)

module nv21cr_yuv2rgb (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        y,
	input  logic [7:0]        u,
	input  logic [7:0]        v,
	output logic signed [8:0] red_norm,
	output logic signed [8:0] green_norm,
	output logic signed [8:0] blue_norm
);

	localparam int SW = 19;

	localparam logic signed [SW-1:0] K_Y  = SW'(nv21cr_pkg::COEF_Y);
	localparam logic signed [SW-1:0] K_RV = SW'(nv21cr_pkg::COEF_RV);
	localparam logic signed [SW-1:0] K_GU = SW'(nv21cr_pkg::COEF_GU);
	localparam logic signed [SW-1:0] K_GV = SW'(nv21cr_pkg::COEF_GV);
	localparam logic signed [SW-1:0] K_BU = SW'(nv21cr_pkg::COEF_BU);
	localparam logic signed [SW-1:0] K_RD = SW'(nv21cr_pkg::ROUND_ADD);
	localparam logic signed [SW-1:0] K_YO = SW'(nv21cr_pkg::Y_OFFSET);
	localparam logic signed [SW-1:0] K_UO = SW'(nv21cr_pkg::UV_OFFSET);

	logic signed [SW-1:0] c_w, d_w, e_w;
	logic signed [SW-1:0] r_sum, g_sum, b_sum;
	logic signed [SW-1:0] r_s1, g_s1, b_s1;
	logic                 valid_s1;
	logic signed [8:0]    r_s2, g_s2, b_s2;

	function automatic logic signed [8:0] norm_chan(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] q;
		logic [7:0]           c8;
		logic signed [9:0]    n;
		q = s >>> 8;
		if (q < 0) begin
			c8 = 8'd0;
		end else if (q > SW'(255)) begin
			c8 = 8'd255;
		end else begin
			c8 = q[7:0];
		end
		n = $signed({1'b0, c8, 1'b0}) - 10'sd255;
		return n[8:0];
	endfunction

	assign c_w = $signed(SW'(y)) - K_YO;
	assign d_w = $signed(SW'(u)) - K_UO;
	assign e_w = $signed(SW'(v)) - K_UO;

	assign r_sum = K_Y * c_w + K_RV * e_w + K_RD;
	assign g_sum = K_Y * c_w - K_GU * d_w - K_GV * e_w + K_RD;
	assign b_sum = K_Y * c_w + K_BU * d_w + K_RD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			r_s1 <= r_sum;
			g_s1 <= g_sum;
			b_s1 <= b_sum;
		end
	end

	// second stage holds until the next conversion
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			r_s2 <= norm_chan(r_s1);
			g_s2 <= norm_chan(g_s1);
			b_s2 <= norm_chan(b_s1);
		end
	end

	assign red_norm   = r_s2;
	assign green_norm = g_s2;
	assign blue_norm  = b_s2;

endmodule

[hw/rtl/nv21_crop_resize_to_rgb_core.sv]
// nv21_crop_resize_to_rgb_core: nv21 frame store, crop box, nearest-neighbor resize, rgb out
// depends on nv21cr_pkg, nv21cr_store, nv21cr_yuv2rgb
//
//  channel | signals                             | word contents (lowest bits first)
//  --------+-------------------------------------+-----------------------------------------
//  s       | s_tvalid s_tready s_tdata s_tuser   | tdata: frame_byte; tuser: command
//  m       | m_tvalid m_tready m_tdata m_tlast   | tdata: red, green, blue, col, row, pad
//          | m_tuser                             | tuser: status; tlast: last grid pixel
//  cfg     | cfg_valid cfg_ready cfg_index       | cfg_data: register value, low bits used
//          | cfg_data                            |
//
// start, load and unused commands leave s_tready high; an emit holds s_tready low through its
// address pipeline (with its multiply steps), the three serial reads (y, v, u) through the single
// read port of the frame store, the conversion and the hand-off to the output register.
// reset clears control state and counters; the frame store has no clearing pass.
// the result register holds while m_tready is low; commands keep being taken meanwhile,
// and an emit that finishes then waits in its last step until the register frees up.

module nv21_crop_resize_to_rgb_core #(
	parameter int MAX_WIDTH  = nv21cr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = nv21cr_pkg::MAX_HEIGHT_DEF,
	parameter int OUT_SIZE   = nv21cr_pkg::OUT_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] frame_byte
	input  logic [1:0]                        s_tuser,   // [1:0] command
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [8:0] red_norm, [17:9] green_norm, [26:18] blue_norm,
	// [34:27] out_col, [42:35] out_row, [47:43] zero
	output logic [47:0]                       m_tdata,
	output logic                              m_tlast,
	output logic [1:0]                        m_tuser,   // [1:0] status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nv21cr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nv21cr_pkg::CFG_DATA_W-1:0] cfg_data
);

	// widths derived from the parameters
	localparam int DEPTH = (MAX_WIDTH * MAX_HEIGHT * 3) / 2;
	localparam int RAW   = $clog2(DEPTH) + 1;
	localparam int XW    = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
	localparam int CLOGN = $clog2(OUT_SIZE);
	localparam int BWW   = $clog2(MAX_WIDTH + 1);
	localparam int BHW   = $clog2(MAX_HEIGHT + 1);

	// floor(p / OUT_SIZE) as (p * ceil(2^S / OUT_SIZE)) >> S, exact for p below 2^PW
	localparam int PXW  = XW + BWW;
	localparam int SXS  = PXW + CLOGN;
	localparam int MXW  = PXW + 1;
	localparam int QXW  = PXW + MXW;
	localparam longint unsigned MX =
		((64'd1 << SXS) + 64'(OUT_SIZE) - 64'd1) / 64'(OUT_SIZE);
	localparam int PYW  = XW + BHW;
	localparam int SYS  = PYW + CLOGN;
	localparam int MYW  = PYW + 1;
	localparam int QYW  = PYW + MYW;
	localparam longint unsigned MY =
		((64'd1 << SYS) + 64'(OUT_SIZE) - 64'd1) / 64'(OUT_SIZE);

	localparam logic [XW-1:0] LAST_IDX = XW'(OUT_SIZE - 1);

	// sequencer steps
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_BOX  = 4'd1;   // clamp box, status
	localparam logic [3:0] S_MUL  = 4'd2;   // index times box size
	localparam logic [3:0] S_DIV  = 4'd3;   // reciprocal multiply
	localparam logic [3:0] S_SAMP = 4'd4;   // sample position
	localparam logic [3:0] S_AMUL = 4'd5;   // row offsets
	localparam logic [3:0] S_ADDR = 4'd6;   // final addresses
	localparam logic [3:0] S_RDY  = 4'd7;   // read y
	localparam logic [3:0] S_RDV  = 4'd8;   // read v, y arrives
	localparam logic [3:0] S_RDU  = 4'd9;   // read u, v arrives
	localparam logic [3:0] S_CONV = 4'd10;  // u arrives, convert
	localparam logic [3:0] S_CNV2 = 4'd11;  // converter second stage
	localparam logic [3:0] S_FIN  = 4'd12;  // hand result to output register

	logic [3:0] state_q, state_d;

	// configuration registers
	logic [9:0]         img_w_q;
	logic [8:0]         img_h_q;
	logic signed [11:0] box_l_q, box_t_q, box_r_q, box_b_q;

	// output grid counters
	logic [XW-1:0] col_q, row_q;

	// per-emit pipeline registers
	logic [XW-1:0]  x_q, y_q;
	logic           last_q;
	logic [1:0]     status_q;
	logic [10:0]    left_q, top_q;
	logic [BWW-1:0] bw_q;
	logic [BHW-1:0] bh_q;
	logic [PXW-1:0] px_q;
	logic [PYW-1:0] py_q;
	logic [BWW-1:0] qx_q;
	logic [BHW-1:0] qy_q;
	logic [9:0]     sx_q;
	logic [8:0]     sy_q;
	logic [18:0]    ymul_q;
	logic [17:0]    uvmul_q;
	logic [18:0]    wh_q;
	logic [RAW-1:0] yi_q, uvi_q;
	logic [7:0]     ysamp_q, vsamp_q;

	// output register
	logic        m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic        m_tlast_q;
	logic [1:0]  m_tuser_q;

	logic in_acc, out_free, emit_acc;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign emit_acc  = in_acc && (s_tuser == nv21cr_pkg::CMD_EMIT);
	assign out_free  = !m_tvalid_q || m_tready;

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= nv21cr_pkg::RST_IMAGE_WIDTH;
			img_h_q <= nv21cr_pkg::RST_IMAGE_HEIGHT;
			box_l_q <= nv21cr_pkg::RST_BOX_LEFT;
			box_t_q <= nv21cr_pkg::RST_BOX_TOP;
			box_r_q <= nv21cr_pkg::RST_BOX_RIGHT;
			box_b_q <= nv21cr_pkg::RST_BOX_BOTTOM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				nv21cr_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg_data[9:0];
				nv21cr_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_data[8:0];
				nv21cr_pkg::REG_BOX_LEFT:     box_l_q <= $signed(cfg_data);
				nv21cr_pkg::REG_BOX_TOP:      box_t_q <= $signed(cfg_data);
				nv21cr_pkg::REG_BOX_RIGHT:    box_r_q <= $signed(cfg_data);
				nv21cr_pkg::REG_BOX_BOTTOM:   box_b_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (emit_acc) state_d = S_BOX;
			S_BOX:  state_d = S_MUL;
			S_MUL:  state_d = S_DIV;
			S_DIV:  state_d = S_SAMP;
			S_SAMP: state_d = S_AMUL;
			S_AMUL: state_d = S_ADDR;
			S_ADDR: state_d = S_RDY;
			S_RDY:  state_d = S_RDV;
			S_RDV:  state_d = S_RDU;
			S_RDU:  state_d = S_CONV;
			S_CONV: state_d = S_CNV2;
			S_CNV2: state_d = S_FIN;
			S_FIN:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// grid counters: cleared by start, stepped by every emit, wrap after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc && (s_tuser == nv21cr_pkg::CMD_START)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (emit_acc) begin
			if (col_q == LAST_IDX) begin
				col_q <= '0;
				row_q <= (row_q == LAST_IDX) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_acc) begin
			x_q    <= col_q;
			y_q    <= row_q;
			last_q <= (col_q == LAST_IDX) && (row_q == LAST_IDX);
		end
	end

	// ---------------------------------------------------------------- box clamp
	logic signed [13:0] w_s, h_s, l_s, t_s, r_s, b_s;
	logic signed [13:0] l_c, t_c, r_c, b_c, bw_c, bh_c;
	logic               size_bad;

	assign w_s = $signed({4'd0, img_w_q});
	assign h_s = $signed({5'd0, img_h_q});
	assign l_s = 14'(box_l_q);
	assign t_s = 14'(box_t_q);
	assign r_s = 14'(box_r_q);
	assign b_s = 14'(box_b_q);

	assign l_c  = (l_s < 0) ? 14'sd0 : l_s;
	assign t_c  = (t_s < 0) ? 14'sd0 : t_s;
	assign r_c  = (r_s > w_s) ? w_s : r_s;
	assign b_c  = (b_s > h_s) ? h_s : b_s;
	assign bw_c = r_c - l_c;
	assign bh_c = b_c - t_c;

	assign size_bad = (img_w_q == '0) || (img_h_q == '0) ||
		({4'd0, img_w_q} > 14'(MAX_WIDTH)) || ({5'd0, img_h_q} > 14'(MAX_HEIGHT));

	always_ff @(posedge clk) begin
		if (state_q == S_BOX) begin
			if (size_bad) begin
				status_q <= nv21cr_pkg::STATUS_BAD_SIZE;
			end else if ((bw_c <= 0) || (bh_c <= 0)) begin
				status_q <= nv21cr_pkg::STATUS_EMPTY_BOX;
			end else begin
				status_q <= nv21cr_pkg::STATUS_OK;
			end
			left_q <= l_c[10:0];
			top_q  <= t_c[10:0];
			bw_q   <= BWW'(bw_c);
			bh_q   <= BHW'(bh_c);
		end
	end

	// ---------------------------------------------------------------- scaling
	logic [QXW-1:0] qx_prod;
	logic [QYW-1:0] qy_prod;

	assign qx_prod = QXW'(px_q) * QXW'(MX);
	assign qy_prod = QYW'(py_q) * QYW'(MY);

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			px_q <= PXW'(x_q) * PXW'(bw_q);
			py_q <= PYW'(y_q) * PYW'(bh_q);
		end
		if (state_q == S_DIV) begin
			qx_q <= qx_prod[SXS +: BWW];
			qy_q <= qy_prod[SYS +: BHW];
		end
	end

	// ---------------------------------------------------------------- sample position
	logic [13:0] sx_c, sy_c;

	assign sx_c = 14'(left_q) + 14'(qx_q);
	assign sy_c = 14'(top_q) + 14'(qy_q);

	always_ff @(posedge clk) begin
		if (state_q == S_SAMP) begin
			sx_q <= (sx_c >= 14'(img_w_q)) ? img_w_q - 1'b1 : sx_c[9:0];
			sy_q <= (sy_c >= 14'(img_h_q)) ? img_h_q - 1'b1 : sy_c[8:0];
		end
	end

	// ---------------------------------------------------------------- store addresses
	// y at sy*w+sx, v/u pair at w*h + (sy/2)*w + even(sx)
	logic [19:0] yi_c, uvi_c;

	assign yi_c  = 20'(ymul_q) + 20'(sx_q);
	assign uvi_c = 20'(wh_q) + 20'(uvmul_q) + 20'({sx_q[9:1], 1'b0});

	always_ff @(posedge clk) begin
		if (state_q == S_AMUL) begin
			ymul_q  <= 19'(sy_q) * 19'(img_w_q);
			uvmul_q <= 18'(sy_q[8:1]) * 18'(img_w_q);
			wh_q    <= 19'(img_w_q) * 19'(img_h_q);
		end
		if (state_q == S_ADDR) begin
			yi_q  <= RAW'(yi_c);
			uvi_q <= RAW'(uvi_c);
		end
	end

	// ---------------------------------------------------------------- frame store
	nv21cr_pkg::store_ctl_t st_ctl;
	logic [RAW-1:0]         st_addr;
	logic [7:0]             st_data;

	always_comb begin
		st_ctl.clear = in_acc && (s_tuser == nv21cr_pkg::CMD_START);
		st_ctl.load  = in_acc && (s_tuser == nv21cr_pkg::CMD_LOAD);
		st_ctl.rd    = (state_q == S_RDY) || (state_q == S_RDV) || (state_q == S_RDU);
		case (state_q)
			S_RDY:   st_addr = yi_q;
			S_RDV:   st_addr = uvi_q;
			S_RDU:   st_addr = uvi_q + 1'b1;
			default: st_addr = yi_q;
		endcase
	end

	nv21cr_store #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.wr_byte (s_tdata),
		.rd_addr (st_addr),
		.rd_data (st_data)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_RDV) begin
			ysamp_q <= st_data;
		end
		if (state_q == S_RDU) begin
			vsamp_q <= st_data;
		end
	end

	// ---------------------------------------------------------------- color conversion
	logic signed [8:0] red_c, green_c, blue_c;

	// u comes straight off the store read port in the convert step
	nv21cr_yuv2rgb u_yuv2rgb (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (state_q == S_CONV),
		.y          (ysamp_q),
		.u          (st_data),
		.v          (vsamp_q),
		.red_norm   (red_c),
		.green_norm (green_c),
		.blue_norm  (blue_c)
	);

	// ---------------------------------------------------------------- output register
	logic              load_out;
	logic              pix_ok;
	logic signed [8:0] red_o, green_o, blue_o;

	assign load_out = (state_q == S_FIN) && out_free;
	assign pix_ok   = (status_q == nv21cr_pkg::STATUS_OK);
	// error results carry zero channels
	assign red_o    = pix_ok ? red_c : 9'sd0;
	assign green_o  = pix_ok ? green_c : 9'sd0;
	assign blue_o   = pix_ok ? blue_c : 9'sd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {5'd0, 8'(y_q), 8'(x_q), blue_o, green_o, red_o};
			m_tlast_q <= last_q;
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

[tb/nv21_crop_resize_to_rgb_core_tb.sv]
// nv21_crop_resize_to_rgb_core_tb: self-checking bench for the nv21 crop/resize/rgb core
// depends on nv21cr_pkg and nv21_crop_resize_to_rgb_core; carries its own pixel predictor
// flow: directed table, then random frames with a calm stretch at the start

module nv21_crop_resize_to_rgb_core_tb;

	localparam int IDX_W       = nv21cr_pkg::CFG_IDX_W;
	localparam int DATA_W      = nv21cr_pkg::CFG_DATA_W;
	localparam int MAX_W       = nv21cr_pkg::MAX_WIDTH_DEF;
	localparam int MAX_H       = nv21cr_pkg::MAX_HEIGHT_DEF;
	localparam int GRID        = nv21cr_pkg::OUT_SIZE_DEF;
	localparam int STORE_DEPTH = MAX_W * MAX_H * 3 / 2;
	localparam int RAND_ITEMS  = 1630;
	localparam int CALM_ITEMS  = 400;  // random words sent with no idling on either side
	localparam int LOAD_CAP    = 300;  // keeps random frames short
	localparam int SETTLE      = 16;   // margin before a register write
	localparam int DRAIN       = 30;

	// codes the package does not name
	localparam logic [1:0]       CMD_UNUSED = 2'd3;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [8:0] red;
		logic signed [8:0] green;
		logic signed [8:0] blue;
		logic [7:0]        col;
		logic [7:0]        row;
		logic              last;
		logic [1:0]        status;
	} pixel_t;

	typedef enum bit {ROW_REG, ROW_WORD} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] val;
		logic [1:0]        cmd;
		logic [7:0]        data;
		bit                typed;   // want holds a hand-written result
		pixel_t            want;
	} step_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata   = '0;
	logic [1:0]        s_tuser   = nv21cr_pkg::CMD_START;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [47:0]       m_tdata;
	logic              m_tlast;
	logic [1:0]        m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_data  = '0;

	nv21_crop_resize_to_rgb_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [7:0] frame_byte
		.s_tuser   (s_tuser),    // [1:0] command
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // red, green, blue, col, row, zero pad
		.m_tlast   (m_tlast),    // last grid pixel
		.m_tuser   (m_tuser),    // [1:0] status
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// calm switches off idling on both sides
	bit calm = 1'b0;

	// receiver: ready low about 35 percent of the time, unless calm
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 35);
	end

	// ---------------------------------------------------------------------------------
	// pixel predictor: mirrored frame store, load pointer, grid counters, registers
	// ---------------------------------------------------------------------------------
	bit [7:0]           frame_mirror [STORE_DEPTH];
	bit                 written_mirror [STORE_DEPTH];
	int                 load_ptr = 0;
	int                 grid_col = 0;
	int                 grid_row = 0;
	logic [9:0]         img_w    = nv21cr_pkg::RST_IMAGE_WIDTH;
	logic [8:0]         img_h    = nv21cr_pkg::RST_IMAGE_HEIGHT;
	logic signed [11:0] box_l    = nv21cr_pkg::RST_BOX_LEFT;
	logic signed [11:0] box_t    = nv21cr_pkg::RST_BOX_TOP;
	logic signed [11:0] box_r    = nv21cr_pkg::RST_BOX_RIGHT;
	logic signed [11:0] box_b    = nv21cr_pkg::RST_BOX_BOTTOM;

	pixel_t expected_pixels [$];
	int     fail_count = 0;

	function automatic int store_byte(int addr);
		return (addr < STORE_DEPTH) ? int'(frame_mirror[addr]) : 0;
	endfunction

	// entries past the store read as zero, so they count as known
	function automatic bit store_known(int addr);
		return (addr >= STORE_DEPTH) || written_mirror[addr];
	endfunction

	// floor(v/256), clamped to 0..255, reported as 2c-255
	function automatic logic signed [8:0] to_norm(int v);
		int q;
		q = v >>> 8;
		if (q < 0)
			q = 0;
		else if (q > 255)
			q = 255;
		return 9'(2 * q - 255);
	endfunction

	// pixel at the current grid position; safe is low when it samples a never-loaded entry
	function automatic pixel_t predict_pixel(output bit safe);
		pixel_t p;
		int     w, h, l, t, rgt, bot, bw, bh, sx, sy, yi, uv_base, c, d, e;
		p = '0;
		safe = 1'b1;
		p.col  = 8'(grid_col);
		p.row  = 8'(grid_row);
		p.last = (grid_col == GRID - 1) && (grid_row == GRID - 1);
		w = int'(img_w);
		h = int'(img_h);
		if (w == 0 || h == 0 || w > MAX_W || h > MAX_H) begin
			p.status = nv21cr_pkg::STATUS_BAD_SIZE;
		end else begin
			l   = (box_l < 0) ? 0 : int'(box_l);
			t   = (box_t < 0) ? 0 : int'(box_t);
			rgt = (box_r > w) ? w : int'(box_r);
			bot = (box_b > h) ? h : int'(box_b);
			bw  = rgt - l;
			bh  = bot - t;
			if (bw <= 0 || bh <= 0) begin
				p.status = nv21cr_pkg::STATUS_EMPTY_BOX;
			end else begin
				// nearest neighbor with exact integer scaling
				sx = l + (grid_col * bw) / GRID;
				sy = t + (grid_row * bh) / GRID;
				if (sx >= w)
					sx = w - 1;
				if (sy >= h)
					sy = h - 1;
				// chroma follows the luma plane as v,u pairs, 2x2 subsampled
				yi      = sy * w + sx;
				uv_base = w * h + (sy / 2) * w + (sx / 2) * 2;
				safe = store_known(yi) && store_known(uv_base) && store_known(uv_base + 1);
				c = store_byte(yi) - nv21cr_pkg::Y_OFFSET;
				e = store_byte(uv_base) - nv21cr_pkg::UV_OFFSET;
				d = store_byte(uv_base + 1) - nv21cr_pkg::UV_OFFSET;
				p.red    = to_norm(nv21cr_pkg::COEF_Y * c + nv21cr_pkg::COEF_RV * e
					+ nv21cr_pkg::ROUND_ADD);
				p.green  = to_norm(nv21cr_pkg::COEF_Y * c - nv21cr_pkg::COEF_GU * d
					- nv21cr_pkg::COEF_GV * e + nv21cr_pkg::ROUND_ADD);
				p.blue   = to_norm(nv21cr_pkg::COEF_Y * c + nv21cr_pkg::COEF_BU * d
					+ nv21cr_pkg::ROUND_ADD);
				p.status = nv21cr_pkg::STATUS_OK;
			end
		end
		return p;
	endfunction

	function automatic void advance_grid();
		grid_col++;
		if (grid_col >= GRID) begin
			grid_col = 0;
			grid_row++;
			if (grid_row >= GRID)
				grid_row = 0;
		end
	endfunction

	// one accepted input word; an emit queues either the typed or the predicted pixel
	function automatic void take_word(logic [1:0] cmd, logic [7:0] data, bit typed,
			pixel_t want);
		pixel_t p;
		bit     safe;
		case (cmd)
			nv21cr_pkg::CMD_START: begin
				load_ptr = 0;
				grid_col = 0;
				grid_row = 0;
			end
			nv21cr_pkg::CMD_LOAD: begin
				// bytes past capacity are dropped
				if (load_ptr < STORE_DEPTH) begin
					frame_mirror[load_ptr]   = data;
					written_mirror[load_ptr] = 1'b1;
					load_ptr++;
				end
			end
			nv21cr_pkg::CMD_EMIT: begin
				p = predict_pixel(safe);
				if (!safe) begin
					fail_count++;
					$display("%0t: emit samples a store entry never loaded", $time);
				end
				advance_grid();
				expected_pixels.push_back(typed ? want : p);
			end
			default: ;
		endcase
	endfunction

	function automatic void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		case (idx)
			nv21cr_pkg::REG_IMAGE_WIDTH:  img_w = val[9:0];
			nv21cr_pkg::REG_IMAGE_HEIGHT: img_h = val[8:0];
			nv21cr_pkg::REG_BOX_LEFT:     box_l = val;
			nv21cr_pkg::REG_BOX_TOP:      box_t = val;
			nv21cr_pkg::REG_BOX_RIGHT:    box_r = val;
			nv21cr_pkg::REG_BOX_BOTTOM:   box_b = val;
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------------------------
	// result checker: every accepted word against the oldest expected pixel
	// ---------------------------------------------------------------------------------
	task automatic show_field(string name, logic signed [9:0] want, logic signed [9:0] got);
		if (got !== want)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
	endtask

	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.red    = m_tdata[8:0];
			got.green  = m_tdata[17:9];
			got.blue   = m_tdata[26:18];
			got.col    = m_tdata[34:27];
			got.row    = m_tdata[42:35];
			got.last   = m_tlast;
			got.status = m_tuser;
			if (expected_pixels.size() == 0) begin
				fail_count++;
				$display("%0t: result word with nothing expected, col %0d row %0d",
					$time, got.col, got.row);
			end else begin
				want = expected_pixels.pop_front();
				if (got !== want) begin
					fail_count++;
					show_field("red_norm", want.red, got.red);
					show_field("green_norm", want.green, got.green);
					show_field("blue_norm", want.blue, got.blue);
					show_field("out_col", want.col, got.col);
					show_field("out_row", want.row, got.row);
					show_field("last", want.last, got.last);
					show_field("status", want.status, got.status);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// drivers; every task is entered and left at a falling edge
	// ---------------------------------------------------------------------------------
	task automatic send_word(logic [1:0] cmd, logic [7:0] data, bit typed = 1'b0,
			pixel_t want = '0);
		while (!calm && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= data;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		take_word(cmd, data, typed, want);
		@(negedge clk);
	endtask

	// an emit that would sample a never-loaded entry goes out as a load instead
	task automatic send_emit();
		bit safe;
		void'(predict_pixel(safe));
		if (safe)
			send_word(nv21cr_pkg::CMD_EMIT, 8'($urandom_range(0, 255)));
		else
			send_word(nv21cr_pkg::CMD_LOAD, 8'($urandom_range(0, 255)));
	endtask

	// leaves cfg_valid high so that writes can follow back to back; caller lowers it
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		set_reg(idx, val);
		@(negedge clk);
	endtask

	// sender holds off until every expected pixel has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (expected_pixels.size() != 0);
	endtask

	// a trailing start or load may still be in flight after the last result
	task automatic wait_idle();
		drain_results();
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_size(int top);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 12'($urandom_range(1, 8));
		if (r < 72)
			return 12'($urandom_range(9, 48));
		if (r < 82)
			return 12'(top);
		if (r < 90)
			return '0;
		// beyond the maximum; upper bits are dropped by the register width
		return 12'($urandom_range(top + 1, 4095));
	endfunction

	function automatic logic [DATA_W-1:0] pick_edge(int lo, int hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 12'(int'($urandom_range(0, hi - lo)) + lo);
		if (r < 85)
			return 12'($urandom_range(0, 4095));
		return (r < 93) ? 12'h800 : 12'h7FF;
	endfunction

	task automatic pick_settings();
		if ($urandom_range(0, 9) < 6) write_reg(nv21cr_pkg::REG_IMAGE_WIDTH, pick_size(MAX_W));
		if ($urandom_range(0, 9) < 6) write_reg(nv21cr_pkg::REG_IMAGE_HEIGHT, pick_size(MAX_H));
		if ($urandom_range(0, 9) < 6) write_reg(nv21cr_pkg::REG_BOX_LEFT, pick_edge(-3, 5));
		if ($urandom_range(0, 9) < 6) write_reg(nv21cr_pkg::REG_BOX_TOP, pick_edge(-3, 5));
		if ($urandom_range(0, 9) < 6) write_reg(nv21cr_pkg::REG_BOX_RIGHT, pick_edge(1, 12));
		if ($urandom_range(0, 9) < 6) write_reg(nv21cr_pkg::REG_BOX_BOTTOM, pick_edge(1, 12));
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------------------------
	// directed table
	// ---------------------------------------------------------------------------------
	step_row_t directed_rows [$];

	function automatic void row_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		step_row_t r;
		r = '{kind: ROW_REG, idx: idx, val: val, cmd: nv21cr_pkg::CMD_START, data: '0,
			typed: 1'b0, want: '0};
		directed_rows.push_back(r);
	endfunction

	function automatic void row_word(logic [1:0] cmd, logic [7:0] data);
		step_row_t r;
		r = '{kind: ROW_WORD, idx: '0, val: '0, cmd: cmd, data: data, typed: 1'b0,
			want: '0};
		directed_rows.push_back(r);
	endfunction

	// error emit on grid row 0: channels zero, column counts up from the start
	function automatic void row_emit_err(logic [1:0] status, int col);
		step_row_t r;
		r = '{kind: ROW_WORD, idx: '0, val: '0, cmd: nv21cr_pkg::CMD_EMIT, data: 8'hC3,
			typed: 1'b1, want: '0};
		r.want.col    = 8'(col);
		r.want.status = status;
		directed_rows.push_back(r);
	endfunction

	// ---------------------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------------------
	initial begin
		int rand_items;
		int nload;
		int nemit;
		int need;
		int w;
		int h;
		int pick;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// size errors, empty boxes, clamped extremes, unused codes, then a tiny frame
		row_reg(nv21cr_pkg::REG_IMAGE_WIDTH, 12'd0);
		row_word(nv21cr_pkg::CMD_START, 8'hFF);
		row_emit_err(nv21cr_pkg::STATUS_BAD_SIZE, 0);
		row_reg(nv21cr_pkg::REG_IMAGE_WIDTH, 12'd700);
		row_emit_err(nv21cr_pkg::STATUS_BAD_SIZE, 1);
		row_reg(nv21cr_pkg::REG_IMAGE_WIDTH, 12'd640);
		row_reg(nv21cr_pkg::REG_IMAGE_HEIGHT, 12'd0);
		row_emit_err(nv21cr_pkg::STATUS_BAD_SIZE, 2);
		row_reg(nv21cr_pkg::REG_IMAGE_HEIGHT, 12'd500);
		row_emit_err(nv21cr_pkg::STATUS_BAD_SIZE, 3);
		row_reg(nv21cr_pkg::REG_IMAGE_HEIGHT, 12'd480);
		row_reg(nv21cr_pkg::REG_BOX_LEFT, 12'd700);
		row_emit_err(nv21cr_pkg::STATUS_EMPTY_BOX, 4);
		row_reg(nv21cr_pkg::REG_BOX_LEFT, 12'h800);
		row_reg(nv21cr_pkg::REG_BOX_RIGHT, 12'h800);
		row_emit_err(nv21cr_pkg::STATUS_EMPTY_BOX, 5);
		row_reg(nv21cr_pkg::REG_BOX_RIGHT, 12'h7FF);
		row_reg(nv21cr_pkg::REG_BOX_TOP, 12'h7FF);
		row_emit_err(nv21cr_pkg::STATUS_EMPTY_BOX, 6);
		row_reg(nv21cr_pkg::REG_BOX_TOP, 12'h800);
		row_reg(nv21cr_pkg::REG_BOX_BOTTOM, 12'd0);
		row_emit_err(nv21cr_pkg::STATUS_EMPTY_BOX, 7);
		row_reg(REG_UNUSED, 12'hFFF);
		row_word(CMD_UNUSED, 8'h00);
		row_emit_err(nv21cr_pkg::STATUS_EMPTY_BOX, 8);
		row_reg(nv21cr_pkg::REG_BOX_BOTTOM, 12'h7FF);
		row_reg(nv21cr_pkg::REG_IMAGE_WIDTH, 12'd2);
		row_reg(nv21cr_pkg::REG_IMAGE_HEIGHT, 12'd2);
		row_word(nv21cr_pkg::CMD_START, 8'h3C);
		row_word(nv21cr_pkg::CMD_LOAD, 8'h00);
		row_word(nv21cr_pkg::CMD_LOAD, 8'hFF);
		row_word(nv21cr_pkg::CMD_LOAD, 8'h10);
		row_word(nv21cr_pkg::CMD_LOAD, 8'hEB);
		row_word(nv21cr_pkg::CMD_LOAD, 8'hFF);
		row_word(nv21cr_pkg::CMD_LOAD, 8'h00);
		row_word(nv21cr_pkg::CMD_EMIT, 8'hFF);
		row_word(nv21cr_pkg::CMD_EMIT, 8'h00);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				if (i == 0 || directed_rows[i - 1].kind != ROW_REG)
					wait_idle();
				write_reg(directed_rows[i].idx, directed_rows[i].val);
				if (i + 1 >= directed_rows.size() || directed_rows[i + 1].kind != ROW_REG)
					cfg_valid <= 1'b0;
			end else begin
				send_word(directed_rows[i].cmd, directed_rows[i].data,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// random frames: new settings, start, load, emits, with some noise mixed in
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			wait_idle();
			calm = (rand_items < CALM_ITEMS);
			pick_settings();
			w = int'(img_w);
			h = int'(img_h);
			if ($urandom_range(0, 9) != 0) begin
				send_word(nv21cr_pkg::CMD_START, 8'($urandom_range(0, 255)));
				rand_items++;
			end
			if (w >= 1 && w <= MAX_W && h >= 1 && h <= MAX_H) begin
				need  = w * h + ((h + 1) / 2) * w + 1;
				nload = (need < LOAD_CAP) ? need : LOAD_CAP;
			end else begin
				nload = $urandom_range(0, 5);
			end
			// now and then a frame that is cut short
			if ($urandom_range(0, 6) == 0)
				nload = $urandom_range(0, nload);
			repeat (nload) send_word(nv21cr_pkg::CMD_LOAD, 8'($urandom_range(0, 255)));
			rand_items += nload;
			nemit = $urandom_range(1, 30);
			repeat (nemit) begin
				pick = $urandom_range(0, 99);
				if (pick < 86) begin
					send_emit();
				end else if (pick < 91) begin
					send_word(nv21cr_pkg::CMD_LOAD, 8'($urandom_range(0, 255)));
				end else if (pick < 94) begin
					send_word(nv21cr_pkg::CMD_START, 8'($urandom_range(0, 255)));
				end else if (pick < 97) begin
					send_word(CMD_UNUSED, 8'($urandom_range(0, 255)));
					rand_items--;
				end else begin
					drain_results();
					send_emit();
				end
				rand_items++;
			end
		end

		calm = 1'b0;
		drain_results();
		repeat (DRAIN) @(negedge clk);
		if (fail_count == 0 && expected_pixels.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit, well beyond the slowest correct run
	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
